FILE: rtl/mf3_pkg.sv
// ----------------------------------------------------------------------------
// mf3_pkg
// Shared constants and types of the 3x3 median filter: limits, derived
// widths, configuration register indexes and the queue item.
// ----------------------------------------------------------------------------
package mf3_pkg;

    localparam int MAX_WIDTH    = 2048;
    localparam int MAX_HEIGHT   = 4096;
    localparam int MAX_CHANNELS = 4;

    localparam int STORE_DEPTH = MAX_WIDTH * MAX_CHANNELS;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int ROWLEN_W    = $clog2(STORE_DEPTH + 1);
    localparam int W_W         = $clog2(MAX_WIDTH + 1);
    localparam int ROW_W       = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int HGT_W       = $clog2(MAX_HEIGHT + 1);
    localparam int CH_W        = $clog2(MAX_CHANNELS + 1);

    // column delay line: two pixels back in the widest channel layout
    localparam int SH_DEPTH = 2 * MAX_CHANNELS;
    localparam int SH_IDX_W = (SH_DEPTH > 1) ? $clog2(SH_DEPTH) : 1;

    // one line store bank per source row: older, previous and current
    localparam int ROW_BANKS = 3;
    localparam int BANK_W    = $clog2(ROW_BANKS);

    localparam int PIX_W = 8;

    localparam int WPIX_CFG_W = 12;
    localparam int CHAN_CFG_W = 3;
    localparam int HGT_CFG_W  = 13;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH_PIXELS = 2'd0,
        CFG_CHANNELS     = 2'd1,
        CFG_IMAGE_HEIGHT = 2'd2
    } t_cfg_idx;

    typedef logic [PIX_W-1:0] t_pix;

    // tap 0: column x, tap 1: column x + c, tap 2: column x + 2c
    typedef logic [2:0][PIX_W-1:0] t_taps;

    typedef struct packed {
        t_taps older;
        t_taps prev;
        t_taps cur;
        logic  has_a;
        logic  has_b;
        logic  a_top_older;
        logic  b_top_prev;
        logic  eoi;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_qwr;

endpackage

FILE: rtl/mf3_ram.sv
// ----------------------------------------------------------------------------
// mf3_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module mf3_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/mf3_front.sv
// ----------------------------------------------------------------------------
// mf3_front
// Intake side: configuration registers, column and row counters, line
// store and column delay lines. Classifies each sample and pushes the
// 3x3 neighbourhood taps of every sample that yields a result.
// ----------------------------------------------------------------------------
module mf3_front import mf3_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    output logic                 o_full,
    input  t_pix                 i_sample,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [Q_CNT_W-1:0]   i_q_count,
    output t_qwr                 o_qwr
);

    logic [WPIX_CFG_W-1:0] r_wpix;
    logic [CHAN_CFG_W-1:0] r_chan;
    logic [HGT_CFG_W-1:0]  r_hgt;
    logic [ADDR_W-1:0]     r_col;
    logic [ROW_W-1:0]      r_row;
    logic [BANK_W-1:0]     r_bank;

    logic                  r_s1_v;
    t_pix                  r_s1_sample;
    logic [BANK_W-1:0]     r_s1_bank;
    logic                  r_s1_has_a;
    logic                  r_s1_has_b;
    logic                  r_s1_a_top_older;
    logic                  r_s1_b_top_prev;
    logic                  r_s1_eoi;

    // row 0: older, row 1: previous, row 2: current
    t_pix                  r_dl [3][SH_DEPTH];

    logic [W_W-1:0]        w_cl;
    logic [CH_W-1:0]       c_cl;
    logic [HGT_W-1:0]      h_cl;
    logic [ROWLEN_W-1:0]   rowlen;
    logic [CH_W:0]         c2;
    logic [SH_IDX_W-1:0]   tap_c;
    logic [SH_IDX_W-1:0]   tap_2c;

    logic                  accept;
    logic [ADDR_W-1:0]     p;
    logic [ROW_W-1:0]      r;
    logic                  ready;
    logic                  last_row;
    logic                  row_end;
    logic [HGT_W-1:0]      r_inc;
    logic [ADDR_W-1:0]     n_col;
    logic [ROW_W-1:0]      n_row;
    logic [BANK_W-1:0]     n_bank;
    logic                  pending;

    logic [BANK_W-1:0]     older_bank;
    logic [BANK_W-1:0]     prev_bank;
    t_pix                  rdata [ROW_BANKS];
    t_pix                  nv [3];

    always_comb begin
        if (r_wpix < WPIX_CFG_W'(3)) begin
            w_cl = W_W'(3);
        end else if (r_wpix > MAX_WIDTH) begin
            w_cl = W_W'(MAX_WIDTH);
        end else begin
            w_cl = W_W'(r_wpix);
        end
        if (r_chan < CHAN_CFG_W'(1)) begin
            c_cl = CH_W'(1);
        end else if (r_chan > MAX_CHANNELS) begin
            c_cl = CH_W'(MAX_CHANNELS);
        end else begin
            c_cl = CH_W'(r_chan);
        end
        if (r_hgt < HGT_CFG_W'(1)) begin
            h_cl = HGT_W'(1);
        end else if (r_hgt > MAX_HEIGHT) begin
            h_cl = HGT_W'(MAX_HEIGHT);
        end else begin
            h_cl = HGT_W'(r_hgt);
        end
    end

    assign rowlen = ROWLEN_W'(w_cl) * ROWLEN_W'(c_cl);
    assign c2     = {c_cl, 1'b0};
    assign tap_c  = SH_IDX_W'(c_cl - 1'b1);
    assign tap_2c = SH_IDX_W'(c2 - 1'b1);

    assign pending = r_s1_v && (r_s1_has_a || r_s1_has_b);
    assign o_full  = (Q_CNT_W'(i_q_count) + Q_CNT_W'(pending)) >= Q_CNT_W'(Q_DEPTH);
    assign accept  = i_push && !o_full;

    always_comb begin
        p        = (ROWLEN_W'(r_col) >= rowlen) ? '0 : r_col;
        r        = (HGT_W'(r_row) >= h_cl) ? '0 : r_row;
        ready    = ROWLEN_W'(p) >= ROWLEN_W'(c2);
        r_inc    = HGT_W'(r) + 1'b1;
        last_row = r_inc == h_cl;
        row_end  = (ROWLEN_W'(p) + 1'b1) == rowlen;
        n_col    = row_end ? '0 : ADDR_W'(p + 1'b1);
        if (!row_end) begin
            n_row = r;
        end else if (r_inc >= h_cl) begin
            n_row = '0;
        end else begin
            n_row = ROW_W'(r_inc);
        end
        if (!row_end) begin
            n_bank = r_bank;
        end else if (r_bank == BANK_W'(ROW_BANKS - 1)) begin
            n_bank = '0;
        end else begin
            n_bank = r_bank + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wpix <= WPIX_CFG_W'(3);
            r_chan <= CHAN_CFG_W'(1);
            r_hgt  <= HGT_CFG_W'(1);
            r_col  <= '0;
            r_row  <= '0;
            r_bank <= '0;
            r_s1_v <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_WIDTH_PIXELS: r_wpix <= i_cfg_data[WPIX_CFG_W-1:0];
                    CFG_CHANNELS:     r_chan <= i_cfg_data[CHAN_CFG_W-1:0];
                    CFG_IMAGE_HEIGHT: r_hgt  <= i_cfg_data[HGT_CFG_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (accept) begin
                r_col  <= n_col;
                r_row  <= n_row;
                r_bank <= n_bank;
            end
            r_s1_v <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_sample      <= i_sample;
            r_s1_bank        <= r_bank;
            r_s1_has_a       <= ready && (r != '0);
            r_s1_has_b       <= ready && last_row;
            r_s1_a_top_older <= r >= ROW_W'(2);
            r_s1_b_top_prev  <= r != '0;
            r_s1_eoi         <= row_end;
        end
    end

    // line store: one bank per source row, roles advance at each row end
    for (genvar gi = 0; gi < ROW_BANKS; gi++) begin : g_bank
        mf3_ram #(
            .WIDTH (PIX_W),
            .DEPTH (STORE_DEPTH)
        ) u_line_store (
            .i_clk   (i_clk),
            .i_we    (accept && (r_bank == BANK_W'(gi))),
            .i_waddr (p),
            .i_wdata (i_sample),
            .i_re    (accept),
            .i_raddr (p),
            .o_rdata (rdata[gi])
        );
    end

    assign older_bank = (r_s1_bank == BANK_W'(ROW_BANKS - 1)) ? '0 : r_s1_bank + 1'b1;
    assign prev_bank  = (r_s1_bank == '0) ? BANK_W'(ROW_BANKS - 1) : r_s1_bank - 1'b1;

    assign nv[0] = rdata[older_bank];
    assign nv[1] = rdata[prev_bank];
    assign nv[2] = r_s1_sample;

    always_ff @(posedge i_clk) begin
        if (r_s1_v) begin
            for (int k = 0; k < 3; k++) begin
                r_dl[k][0] <= nv[k];
                for (int j = 1; j < SH_DEPTH; j++) begin
                    r_dl[k][j] <= r_dl[k][j-1];
                end
            end
        end
    end

    always_comb begin
        o_qwr.valid            = pending;
        o_qwr.item.older[0]    = r_dl[0][tap_2c];
        o_qwr.item.older[1]    = r_dl[0][tap_c];
        o_qwr.item.older[2]    = nv[0];
        o_qwr.item.prev[0]     = r_dl[1][tap_2c];
        o_qwr.item.prev[1]     = r_dl[1][tap_c];
        o_qwr.item.prev[2]     = nv[1];
        o_qwr.item.cur[0]      = r_dl[2][tap_2c];
        o_qwr.item.cur[1]      = r_dl[2][tap_c];
        o_qwr.item.cur[2]      = nv[2];
        o_qwr.item.has_a       = r_s1_has_a;
        o_qwr.item.has_b       = r_s1_has_b;
        o_qwr.item.a_top_older = r_s1_a_top_older;
        o_qwr.item.b_top_prev  = r_s1_b_top_prev;
        o_qwr.item.eoi         = r_s1_eoi;
    end

endmodule

FILE: rtl/mf3_fifo.sv
// ----------------------------------------------------------------------------
// mf3_fifo
// Short register queue between intake and median pipeline.
// ----------------------------------------------------------------------------
module mf3_fifo import mf3_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_qwr               i_wr,
    input  logic               i_pop,
    output logic               o_valid,
    output t_item              o_item,
    output logic [Q_CNT_W-1:0] o_count
);

    t_item               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]  r_wp;
    logic [Q_PTR_W-1:0]  r_rp;
    logic [Q_CNT_W-1:0]  r_cnt;
    logic [Q_PTR_W-1:0]  n_wp;
    logic [Q_PTR_W-1:0]  n_rp;
    logic                pop_fire;

    assign o_valid  = r_cnt != '0;
    assign o_item   = r_mem[r_rp];
    assign o_count  = r_cnt;
    assign pop_fire = i_pop && o_valid;

    assign n_wp = (r_wp == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wp + 1'b1;
    assign n_rp = (r_rp == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rp + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_wr.valid) begin
                r_wp <= n_wp;
            end
            if (pop_fire) begin
                r_rp <= n_rp;
            end
            if (i_wr.valid && !pop_fire) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_wr.valid && pop_fire) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.valid) begin
            r_mem[r_wp] <= i_wr.item;
        end
    end

endmodule

FILE: rtl/mf3_back.sv
// ----------------------------------------------------------------------------
// mf3_back
// Median pipeline: selects the clamped neighbourhoods, runs the 19-step
// compare-exchange network over three stages and emits one or two
// results per item from the output register.
// ----------------------------------------------------------------------------
module mf3_back import mf3_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_q_valid,
    input  t_item i_q_item,
    output logic  o_q_pop,
    input  logic  i_pop,
    output logic  o_empty,
    output t_pix  o_median,
    output logic  o_last,
    output logic  o_end_of_image
);

    typedef logic [8:0][PIX_W-1:0] t_win;

    typedef struct packed {
        logic has_a;
        logic has_b;
        logic eoi;
    } t_flags;

    function automatic t_win cxw(t_win w, int lo, int hi);
        t_win v;
        v = w;
        if (w[hi] < w[lo]) begin
            v[lo] = w[hi];
            v[hi] = w[lo];
        end
        return v;
    endfunction

    function automatic t_win net_p1(t_win w);
        t_win v;
        v = w;
        v = cxw(v, 1, 2); v = cxw(v, 4, 5); v = cxw(v, 7, 8);
        v = cxw(v, 0, 1); v = cxw(v, 3, 4); v = cxw(v, 6, 7);
        v = cxw(v, 1, 2); v = cxw(v, 4, 5); v = cxw(v, 7, 8);
        return v;
    endfunction

    function automatic t_win net_p2(t_win w);
        t_win v;
        v = w;
        v = cxw(v, 0, 3); v = cxw(v, 5, 8); v = cxw(v, 4, 7);
        v = cxw(v, 3, 6); v = cxw(v, 1, 4); v = cxw(v, 2, 5);
        v = cxw(v, 4, 7);
        return v;
    endfunction

    function automatic t_pix net_p3(t_win w);
        t_win v;
        v = w;
        v = cxw(v, 4, 2); v = cxw(v, 6, 4); v = cxw(v, 4, 2);
        return v[4];
    endfunction

    function automatic t_win make_win(t_taps top, t_taps mid, t_taps bot);
        t_win v;
        for (int j = 0; j < 3; j++) begin
            v[j]     = top[j];
            v[j + 3] = mid[j];
            v[j + 6] = bot[j];
        end
        return v;
    endfunction

    logic   r_b1_v;
    t_win   r_b1_wa;
    t_win   r_b1_wb;
    t_flags r_b1_fl;
    logic   r_b2_v;
    t_win   r_b2_wa;
    t_win   r_b2_wb;
    t_flags r_b2_fl;
    logic   r_out_v;
    t_pix   r_out_ma;
    t_pix   r_out_mb;
    t_flags r_out_fl;
    logic   r_out_sent_a;

    t_win   n_b1_wa;
    t_win   n_b1_wb;
    t_flags n_b1_fl;

    logic   both;
    logic   final_res;
    logic   pop_fire;
    logic   go1;
    logic   go2;
    logic   go3;

    always_comb begin
        n_b1_wa = net_p1(make_win(i_q_item.a_top_older ? i_q_item.older : i_q_item.prev,
                                  i_q_item.prev, i_q_item.cur));
        n_b1_wb = net_p1(make_win(i_q_item.b_top_prev ? i_q_item.prev : i_q_item.cur,
                                  i_q_item.cur, i_q_item.cur));
        n_b1_fl = '{has_a: i_q_item.has_a, has_b: i_q_item.has_b, eoi: i_q_item.eoi};
    end

    assign both      = r_out_fl.has_a && r_out_fl.has_b;
    assign final_res = !both || r_out_sent_a;
    assign pop_fire  = i_pop && r_out_v;
    assign go3       = !r_out_v || (pop_fire && final_res);
    assign go2       = !r_b2_v || go3;
    assign go1       = !r_b1_v || go2;
    assign o_q_pop   = i_q_valid && go1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_v       <= 1'b0;
            r_b2_v       <= 1'b0;
            r_out_v      <= 1'b0;
            r_out_sent_a <= 1'b0;
        end else begin
            if (go1) begin
                r_b1_v <= i_q_valid;
            end
            if (go2) begin
                r_b2_v <= r_b1_v;
            end
            if (go3) begin
                r_out_v      <= r_b2_v;
                r_out_sent_a <= 1'b0;
            end else if (pop_fire) begin
                r_out_sent_a <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (go1) begin
            r_b1_wa <= n_b1_wa;
            r_b1_wb <= n_b1_wb;
            r_b1_fl <= n_b1_fl;
        end
        if (go2) begin
            r_b2_wa <= net_p2(r_b1_wa);
            r_b2_wb <= net_p2(r_b1_wb);
            r_b2_fl <= r_b1_fl;
        end
        if (go3) begin
            r_out_ma <= net_p3(r_b2_wa);
            r_out_mb <= net_p3(r_b2_wb);
            r_out_fl <= r_b2_fl;
        end
    end

    assign o_empty        = !r_out_v;
    assign o_median       = (r_out_fl.has_a && !(both && r_out_sent_a)) ? r_out_ma : r_out_mb;
    assign o_last         = final_res;
    assign o_end_of_image = r_out_fl.eoi && r_out_fl.has_b && final_res;

endmodule

FILE: rtl/median3x3_sorting_network_filter.sv
// ----------------------------------------------------------------------------
// median3x3_sorting_network_filter
// 3x3 median filter over a raster-order byte stream, channels interleaved.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue port: drive i_sample with push; a sample is taken on a
//   clock edge with push high and full low. Result queue port: o_median,
//   o_last and o_end_of_image are valid while empty is low; pop takes one.
//   Configuration: i_cfg_index/i_cfg_data with i_cfg_valid; o_cfg_ready is
//   always high. Write registers only between images.
// Timing:
//   A sample that yields a result passes the intake register, the queue and
//   the pipeline registers to the result port. One sample is taken per cycle
//   while full is low; in the last row of a multi-row image each sample past
//   the first two pixels yields two results, so the result port paces intake.
//   The line store is three RAMs of MAX_WIDTH*MAX_CHANNELS bytes, one per source
//   row; the sample is written and the two older rows are read at intake.
// Reset:
//   Clears counters, the queue and the pipeline; registers return to
//   width 3, one channel, height 1. Line store contents stay undefined.
// Stall:
//   With pop low the result holds; the queue fills and full rises, so
//   intake stops without losing samples.
// ----------------------------------------------------------------------------
module median3x3_sorting_network_filter import mf3_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [PIX_W-1:0]      i_sample,
    output logic                  empty,
    input  logic                  pop,
    output logic [PIX_W-1:0]      o_median,
    output logic                  o_last,
    output logic                  o_end_of_image,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_qwr               qwr;
    logic               q_pop;
    logic               q_valid;
    t_item              q_item;
    logic [Q_CNT_W-1:0] q_count;

    assign o_cfg_ready = 1'b1;

    mf3_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_sample    (i_sample),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_count   (q_count),
        .o_qwr       (qwr)
    );

    mf3_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (qwr),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_item),
        .o_count (q_count)
    );

    mf3_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_q_item       (q_item),
        .o_q_pop        (q_pop),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_median       (o_median),
        .o_last         (o_last),
        .o_end_of_image (o_end_of_image)
    );

endmodule

FILE: rtl/mf3_checker.sv
// ----------------------------------------------------------------------------
// mf3_checker
// Port-level checks of the median filter, bound to the top level.
// ----------------------------------------------------------------------------
module mf3_checker import mf3_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             full,
    input logic             empty,
    input logic             pop,
    input logic [PIX_W-1:0] o_median,
    input logic             o_last,
    input logic             o_end_of_image
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("reset did not clear result and intake state");

    a_eoi_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_end_of_image |-> o_last)
        else $error("end of image on a non-final result");

    a_pair_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop && !empty && !o_last |=> !empty && o_last)
        else $error("second result of a pair not presented next");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_median) && $stable(o_last)
            && $stable(o_end_of_image))
        else $error("stalled result transaction changed");

endmodule

bind median3x3_sorting_network_filter mf3_checker u_mf3_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .full           (full),
    .empty          (empty),
    .pop            (pop),
    .o_median       (o_median),
    .o_last         (o_last),
    .o_end_of_image (o_end_of_image)
);
